// File: rtl/core/pffla_pkg.sv
// pffla_pkg: shared constants, status codes and control/status structs
// for the page frame free list allocator; no dependencies
`timescale 1ns / 1ps

package pffla_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 128;
  localparam int unsigned PAGE_SHIFT     = 21;

  localparam int unsigned FRAME_W    = 8;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned ADDR_W     = 28;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC_OK   = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREE_DONE  = 2'd2
  } status_e;

  typedef struct packed {
    logic init_step;
    logic load_req;
    logic rd_head;
    logic rd_start;
    logic step;
    logic wr_cut;
    logic wr_splice;
    logic out_ok;
    logic out_fail;
    logic out_free;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic kind;
    logic want_zero;
    logic head_null;
    logic start_null;
    logic link_null;
    logic cnt_lt_want;
    logic cnt_lt_max;
    logic out_room;
  } sts_t;

endpackage

// File: rtl/core/pffla_dpath.sv
// pffla_dpath: next-link memory, free head, walk registers and result register
// depends on pffla_pkg; driven by pffla_ctrl
`timescale 1ns / 1ps

module pffla_dpath #(
  parameter int unsigned NUM_FRAMES = pffla_pkg::NUM_FRAMES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pffla_pkg::cmd_t                     cmd_i,
  output pffla_pkg::sts_t                     sts_o,
  input  logic                                req_kind_i,
  input  logic [pffla_pkg::COUNT_W-1:0]       req_pages_i,
  input  logic [pffla_pkg::FRAME_W-1:0]       req_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pffla_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int unsigned LW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned AW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = (LW > pffla_pkg::COUNT_W) ? LW : pffla_pkg::COUNT_W;
  localparam int unsigned PW = pffla_pkg::OUT_DATA_W - pffla_pkg::STATUS_W
                               - 2 * pffla_pkg::FRAME_W - pffla_pkg::ADDR_W;

  localparam logic [LW-1:0] Nil     = LW'(NUM_FRAMES);
  localparam logic [CW-1:0] NilC    = CW'(NUM_FRAMES);
  localparam logic [AW-1:0] LastIdx = AW'(NUM_FRAMES - 1);

  logic [LW-1:0] mem [NUM_FRAMES];
  logic [LW-1:0] rd_data_q;

  logic [AW-1:0] init_q, init_d;
  logic [LW-1:0] head_q, head_d;
  logic          kind_q;
  logic [pffla_pkg::COUNT_W-1:0] want_q;
  logic [pffla_pkg::FRAME_W-1:0] start_q;
  logic [AW-1:0] cur_q;
  logic [CW-1:0] cnt_q;

  logic                           out_valid_q, out_valid_d;
  pffla_pkg::status_e             out_status_q;
  logic [pffla_pkg::FRAME_W-1:0]  out_frame_q;
  logic [pffla_pkg::ADDR_W-1:0]   out_addr_q;
  logic [pffla_pkg::COUNT_W-1:0]  out_granted_q;

  logic [CW-1:0]   start_c;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic            mem_re;
  logic [LW-1:0]   mem_wd;
  logic [pffla_pkg::ADDR_W+LW-1:0] addr_wide;

  assign start_c   = CW'(start_q);
  assign addr_wide = {{pffla_pkg::ADDR_W{1'b0}}, head_q} << pffla_pkg::PAGE_SHIFT;

  // single port address and write data select
  always_comb begin
    mem_addr = cur_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wd   = Nil;
    if (cmd_i.init_step) begin
      mem_addr = init_q;
      mem_we   = 1'b1;
      mem_wd   = LW'(init_q) + LW'(1);
    end else if (cmd_i.rd_head) begin
      mem_addr = head_q[AW-1:0];
      mem_re   = 1'b1;
    end else if (cmd_i.rd_start) begin
      mem_addr = start_c[AW-1:0];
      mem_re   = 1'b1;
    end else if (cmd_i.step) begin
      mem_addr = rd_data_q[AW-1:0];
      mem_re   = 1'b1;
    end else if (cmd_i.wr_cut) begin
      mem_we   = 1'b1;
      mem_wd   = Nil;
    end else if (cmd_i.wr_splice) begin
      mem_we   = 1'b1;
      mem_wd   = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  always_comb begin
    init_d = init_q;
    if (cmd_i.init_step) begin
      init_d = init_q + AW'(1);
    end
    head_d = head_q;
    if (cmd_i.wr_cut) begin
      head_d = rd_data_q;
    end else if (cmd_i.wr_splice) begin
      head_d = LW'(start_c);
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_ok || cmd_i.out_fail || cmd_i.out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      init_q      <= init_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q  <= req_kind_i;
      want_q  <= req_pages_i;
      start_q <= req_start_i;
    end
    if (cmd_i.rd_head) begin
      cur_q <= head_q[AW-1:0];
      cnt_q <= CW'(1);
    end else if (cmd_i.rd_start) begin
      cur_q <= start_c[AW-1:0];
      cnt_q <= CW'(1);
    end else if (cmd_i.step) begin
      cur_q <= rd_data_q[AW-1:0];
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ok) begin
      out_status_q  <= pffla_pkg::ST_ALLOC_OK;
      out_frame_q   <= pffla_pkg::FRAME_W'(head_q);
      out_addr_q    <= addr_wide[pffla_pkg::ADDR_W-1:0];
      out_granted_q <= pffla_pkg::COUNT_W'(cnt_q);
    end else if (cmd_i.out_fail || cmd_i.out_free) begin
      out_status_q  <= cmd_i.out_fail ? pffla_pkg::ST_ALLOC_FAIL : pffla_pkg::ST_FREE_DONE;
      out_frame_q   <= pffla_pkg::FRAME_W'(Nil);
      out_addr_q    <= '0;
      out_granted_q <= '0;
    end
  end

  assign sts_o.init_last   = (init_q == LastIdx);
  assign sts_o.kind        = kind_q;
  assign sts_o.want_zero   = (want_q == '0);
  assign sts_o.head_null   = (head_q >= Nil);
  assign sts_o.start_null  = (start_c >= NilC);
  assign sts_o.link_null   = (rd_data_q >= Nil);
  assign sts_o.cnt_lt_want = (cnt_q < CW'(want_q));
  assign sts_o.cnt_lt_max  = (cnt_q < NilC);
  assign sts_o.out_room    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{PW{1'b0}}, out_granted_q, out_addr_q, out_frame_q, out_status_q};

endmodule

// File: rtl/core/pffla_ctrl.sv
// pffla_ctrl: sequencer for reset sweep, allocate walk and free walk
// depends on pffla_pkg; commands pffla_dpath
`timescale 1ns / 1ps

module pffla_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pffla_pkg::sts_t sts_i,
  output pffla_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_WALK_A,
    S_CUT,
    S_WALK_F,
    S_SPLICE,
    S_FAIL,
    S_FREE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.kind == pffla_pkg::KIND_ALLOC) begin
          if (sts_i.want_zero || sts_i.head_null) begin
            state_d = S_FAIL;
          end else begin
            cmd_o.rd_head = 1'b1;
            state_d       = S_WALK_A;
          end
        end else begin
          if (sts_i.start_null) begin
            state_d = S_FREE;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d        = S_WALK_F;
          end
        end
      end
      S_WALK_A: begin
        if (sts_i.cnt_lt_want && !sts_i.link_null) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_CUT;
        end
      end
      S_CUT: begin
        if (sts_i.out_room) begin
          cmd_o.wr_cut = 1'b1;
          cmd_o.out_ok = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_WALK_F: begin
        if (sts_i.cnt_lt_max && !sts_i.link_null) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_SPLICE;
        end
      end
      S_SPLICE: begin
        if (sts_i.out_room) begin
          cmd_o.wr_splice = 1'b1;
          cmd_o.out_free  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_FAIL: begin
        if (sts_i.out_room) begin
          cmd_o.out_fail = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FREE: begin
        if (sts_i.out_room) begin
          cmd_o.out_free = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: rtl/core/page_frame_free_list_allocator.sv
// Page frame allocator keeping free frames as a singly linked list in a one-port
// next-link memory. After reset the block sweeps the memory to link every frame in
// ascending order before the first request is accepted. A request then runs one
// link per cycle through that memory: an allocate walks up to n frames from the
// free head, a free walks a chain of m frames to its tail, and a failed allocate
// or a null free walks none. One request is in work at a time; its result sits in
// an output register so the next request may be accepted while the result waits.
// depends on pffla_pkg, pffla_ctrl and pffla_dpath
`timescale 1ns / 1ps

module page_frame_free_list_allocator #(
  parameter int unsigned NUM_FRAMES = pffla_pkg::NUM_FRAMES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pages_requested, chain_start
  input  logic [pffla_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // kind
  input  logic [0:0]                         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status, first_frame, first_frame_address, pages_granted, zero fill
  output logic [pffla_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  pffla_pkg::cmd_t cmd;
  pffla_pkg::sts_t sts;

  pffla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pffla_dpath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_kind_i  (s_axis_tuser_i[0]),
    .req_pages_i (s_axis_tdata_i[pffla_pkg::COUNT_W-1:0]),
    .req_start_i (s_axis_tdata_i[pffla_pkg::COUNT_W +: pffla_pkg::FRAME_W]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// File: test/page_frame_free_list_allocator_tb.sv
// page_frame_free_list_allocator_tb: stream testbench for the page frame allocator,
// checking every result against a frame pool predictor kept in step with the dut
// depends on pffla_pkg and page_frame_free_list_allocator
`timescale 1ns / 1ps

module page_frame_free_list_allocator_tb;

  localparam int unsigned NUM_FRAMES = pffla_pkg::NUM_FRAMES_DEF;
  localparam logic [pffla_pkg::FRAME_W-1:0] FRAME_NIL = pffla_pkg::FRAME_W'(NUM_FRAMES);

  typedef struct {
    pffla_pkg::status_e                status;
    logic [pffla_pkg::FRAME_W-1:0]     first_frame;
    logic [pffla_pkg::ADDR_W-1:0]      address;
    logic [pffla_pkg::COUNT_W-1:0]     granted;
  } frame_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [pffla_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [0:0]                       s_axis_tuser_i = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [pffla_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  logic [pffla_pkg::FRAME_W-1:0] pool_link [NUM_FRAMES];
  logic [pffla_pkg::FRAME_W-1:0] pool_head;
  frame_result_t                 results_due [$];
  logic [pffla_pkg::FRAME_W-1:0] held_chains [$];
  int                            error_count = 0;
  int                            send_idle_pct = 10;
  int                            recv_idle_pct = 81;

  page_frame_free_list_allocator #(
    .NUM_FRAMES(NUM_FRAMES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void reset_pool();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      pool_link[i] = (i + 1 < NUM_FRAMES) ? pffla_pkg::FRAME_W'(i + 1) : FRAME_NIL;
    end
    pool_head = '0;
  endfunction

  // allocate from the head or splice a chain in front of it
  function automatic frame_result_t serve_request(input logic kind,
                                                  input logic [pffla_pkg::COUNT_W-1:0] want,
                                                  input logic [pffla_pkg::FRAME_W-1:0] start);
    frame_result_t r;
    int cur;
    int count;
    int tail;
    int steps;
    r.status      = pffla_pkg::ST_FREE_DONE;
    r.first_frame = FRAME_NIL;
    r.address     = '0;
    r.granted     = '0;
    if (kind == pffla_pkg::KIND_ALLOC) begin
      if (int'(pool_head) >= NUM_FRAMES || want == 0) begin
        r.status = pffla_pkg::ST_ALLOC_FAIL;
      end else begin
        cur   = int'(pool_head);
        count = 1;
        while (count < int'(want) && int'(pool_link[cur]) < NUM_FRAMES) begin
          cur = int'(pool_link[cur]);
          count++;
        end
        r.status      = pffla_pkg::ST_ALLOC_OK;
        r.first_frame = pool_head;
        r.address     = {20'd0, pool_head} << pffla_pkg::PAGE_SHIFT;
        r.granted     = pffla_pkg::COUNT_W'(count);
        pool_head     = pool_link[cur];
        pool_link[cur] = FRAME_NIL;
      end
    end else if (int'(start) < NUM_FRAMES) begin
      tail  = int'(start);
      steps = 0;
      while (int'(pool_link[tail]) < NUM_FRAMES && steps + 1 < NUM_FRAMES) begin
        tail = int'(pool_link[tail]);
        steps++;
      end
      pool_link[tail] = pool_head;
      pool_head       = start;
    end
    return r;
  endfunction

  task automatic send_request(input logic kind, input logic [pffla_pkg::COUNT_W-1:0] want,
                              input logic [pffla_pkg::FRAME_W-1:0] start);
    frame_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {start, want};
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = serve_request(kind, want, start);
    results_due.push_back(r);
    if (r.status == pffla_pkg::ST_ALLOC_OK) held_chains.push_back(r.first_frame);
  endtask

  task automatic alloc_pages(input int want);
    send_request(pffla_pkg::KIND_ALLOC, pffla_pkg::COUNT_W'(want),
                 pffla_pkg::FRAME_W'($urandom_range(NUM_FRAMES)));
  endtask

  task automatic free_chain(input int start);
    send_request(pffla_pkg::KIND_FREE, pffla_pkg::COUNT_W'($urandom_range(NUM_FRAMES)),
                 pffla_pkg::FRAME_W'(start));
  endtask

  task automatic free_held(input int idx);
    logic [pffla_pkg::FRAME_W-1:0] head;
    head = held_chains[idx];
    held_chains.delete(idx);
    free_chain(int'(head));
  endtask

  task automatic free_all_held();
    while (held_chains.size() != 0) free_held(0);
  endtask

  task automatic report_field(input string name, input logic [pffla_pkg::ADDR_W-1:0] exp_v,
                              input logic [pffla_pkg::ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    frame_result_t r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected, actual %0h", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        r = results_due.pop_front();
        report_field("status", pffla_pkg::ADDR_W'(r.status),
                     pffla_pkg::ADDR_W'(m_axis_tdata_o[1:0]));
        report_field("first_frame", pffla_pkg::ADDR_W'(r.first_frame),
                     pffla_pkg::ADDR_W'(m_axis_tdata_o[9:2]));
        report_field("first_frame_address", r.address, m_axis_tdata_o[37:10]);
        report_field("pages_granted", pffla_pkg::ADDR_W'(r.granted),
                     pffla_pkg::ADDR_W'(m_axis_tdata_o[45:38]));
        report_field("zero fill", pffla_pkg::ADDR_W'(0),
                     pffla_pkg::ADDR_W'(m_axis_tdata_o[47:46]));
      end
    end
  end

  task automatic test_zero_request();
    alloc_pages(0);
    alloc_pages(1);
    free_all_held();
  endtask

  // whole pool taken, then the empty list refuses
  task automatic test_empty_list();
    alloc_pages(1);
    alloc_pages(NUM_FRAMES);
    alloc_pages(1);
    alloc_pages(0);
    free_held(1);
    free_held(0);
  endtask

  task automatic test_partial_grant();
    alloc_pages(100);
    alloc_pages(50);
    alloc_pages(3);
    free_held(0);
    free_held(0);
  endtask

  task automatic test_null_free();
    free_chain(NUM_FRAMES);
    alloc_pages(2);
    free_chain(NUM_FRAMES);
    free_all_held();
  endtask

  task automatic test_full_pool();
    alloc_pages(NUM_FRAMES);
    free_all_held();
    alloc_pages(NUM_FRAMES - 1);
    alloc_pages(NUM_FRAMES);
    free_all_held();
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    int sel;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        free_chain(NUM_FRAMES);
      end else if (pick < 50 || held_chains.size() == 0) begin
        sel = $urandom_range(99);
        if (sel < 3)       alloc_pages(0);
        else if (sel < 88) alloc_pages($urandom_range(8, 1));
        else if (sel < 97) alloc_pages($urandom_range(40, 9));
        else               alloc_pages($urandom_range(NUM_FRAMES, 41));
      end else begin
        free_held($urandom_range(held_chains.size() - 1));
      end
    end
  endtask

  // frees of frames that head no allocated chain, which may leave the list cyclic
  task automatic test_stray_free();
    free_all_held();
    free_chain(int'(pool_head));
    alloc_pages(NUM_FRAMES);
    repeat (4) free_chain($urandom_range(NUM_FRAMES - 1));
    alloc_pages($urandom_range(NUM_FRAMES, 1));
    free_chain(NUM_FRAMES - 1);
    alloc_pages(NUM_FRAMES);
    free_chain(0);
    alloc_pages(1);
  endtask

  initial begin
    reset_pool();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_request();
    test_empty_list();
    test_partial_grant();
    test_null_free();
    test_full_pool();

    test_random_traffic(405);
    send_idle_pct = 81;
    recv_idle_pct = 10;
    test_random_traffic(405);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(405);

    test_stray_free();

    s_axis_tvalid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (NUM_FRAMES + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: page_frame_free_list_allocator.f
rtl/core/pffla_pkg.sv
rtl/core/pffla_dpath.sv
rtl/core/pffla_ctrl.sv
rtl/core/page_frame_free_list_allocator.sv
test/page_frame_free_list_allocator_tb.sv
